// ===== sv/sqs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the stack and queue store: sizes, request and status codes,
// and the one-hot controller states. No dependencies.
package sqs_pkg;

    localparam int DEPTH     = 128;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH    = 3'd0,
        REQ_POP     = 3'd1,
        REQ_ENQUEUE = 3'd2,
        REQ_DEQUEUE = 3'd3,
        REQ_SWITCH  = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_XFER = 3'b100
    } t_state;

endpackage

// ===== sv/sqs_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. Depends on nothing.
module sqs_ram #(
    parameter int AW = 7,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/stack_queue_store_with_mode_transfer_top.sv =====
`timescale 1ns / 1ps
// Top level of the stack and queue store with mode transfer.
// Depends on sqs_pkg and on sqs_ram (one instance for each store).
//
//  Channel   Signals                                         Direction
//  --------  ----------------------------------------------  ---------
//  request   i_in_valid, o_in_stall, i_req_type, i_value      in
//  result    o_out_valid, i_out_stall, o_data, o_status,      out
//            o_mode_now, o_stack_count, o_queue_count
//
// For push, enqueue, unknown codes and refused requests the result beat is
// shown in the next cycle. Pop and dequeue first read the memory, whose
// read is registered, and load the result from the read state. A mode
// switch moves its entries at one entry a cycle: each is read from one
// memory while the entry before it is written into the other.
// Reset is synchronous and active low; it empties both stores and selects
// stack mode without touching the memories. A stalled result beat holds in
// the output register, and a new request is taken only once that register
// is free or being emptied in the same cycle.
module stack_queue_store_with_mode_transfer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [sqs_pkg::REQ_W-1:0]            i_req_type,
    input  logic signed [sqs_pkg::DATA_W-1:0]    i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [sqs_pkg::DATA_W-1:0]    o_data,
    output logic [sqs_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_mode_now,
    output logic [sqs_pkg::OUT_CNT_W-1:0]        o_stack_count,
    output logic [sqs_pkg::OUT_CNT_W-1:0]        o_queue_count
);

    import sqs_pkg::*;

    // Controller state. The stack pointer counts entries; the queue keeps a
    // head, a tail and a flag for "holds at least one entry".
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [ADDR_W-1:0]   r_tail, n_tail;
    logic                r_ne, n_ne;
    logic                r_mode, n_mode;
    logic                r_pend, n_pend;
    logic                r_out_valid;

    // Payload registers, no reset needed.
    logic [ADDR_W-1:0]   r_wr_addr, n_wr_addr;
    logic                r_rd_q, n_rd_q;
    logic [DATA_W-1:0]   r_out_data;
    t_status             r_out_status;
    logic                r_out_mode;
    logic [OUT_CNT_W-1:0] r_out_scnt;
    logic [OUT_CNT_W-1:0] r_out_qcnt;

    // Memory ports.
    logic                s_we, s_re, q_we, q_re;
    logic [ADDR_W-1:0]   s_waddr, s_raddr, q_waddr, q_raddr;
    logic [DATA_W-1:0]   s_wdata, q_wdata, s_rdata, q_rdata;

    // Result load.
    logic                ld;
    logic [DATA_W-1:0]   ld_data;
    t_status             ld_status;
    logic [CNT_W-1:0]    ld_qcnt;

    logic                accept;
    logic [CNT_W-1:0]    fill_m1;
    logic                stack_full;
    logic                queue_can_take;
    logic [ADDR_W-1:0]   tail_p1;
    logic [ADDR_W-1:0]   head_p1;

    sqs_ram #(.AW(ADDR_W), .DW(DATA_W)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    sqs_ram #(.AW(ADDR_W), .DW(DATA_W)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // A request is taken only in idle, and only when the result register
    // will be free at the following edge.
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    assign fill_m1        = r_fill - CNT_W'(1);
    assign stack_full     = (r_fill == CNT_W'(DEPTH));
    assign queue_can_take = !r_ne || (r_tail != ADDR_W'(DEPTH - 1));
    assign tail_p1        = r_tail + ADDR_W'(1);
    assign head_p1        = r_head + ADDR_W'(1);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_head    = r_head;
        n_tail    = r_tail;
        n_ne      = r_ne;
        n_mode    = r_mode;
        n_pend    = r_pend;
        n_wr_addr = r_wr_addr;
        n_rd_q    = r_rd_q;
        s_we      = 1'b0;
        s_waddr   = r_fill[ADDR_W-1:0];
        s_wdata   = i_value;
        s_re      = 1'b0;
        s_raddr   = fill_m1[ADDR_W-1:0];
        q_we      = 1'b0;
        q_waddr   = tail_p1;
        q_wdata   = i_value;
        q_re      = 1'b0;
        q_raddr   = r_head;
        ld        = 1'b0;
        ld_data   = '0;
        ld_status = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_req'(i_req_type))
                        REQ_PUSH: begin
                            ld = 1'b1;
                            if (stack_full) begin
                                ld_status = ST_FULL;
                            end else begin
                                s_we   = 1'b1;
                                n_fill = r_fill + CNT_W'(1);
                            end
                        end
                        REQ_POP: begin
                            if (r_fill == '0) begin
                                ld        = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                s_re    = 1'b1;
                                n_fill  = fill_m1;
                                n_rd_q  = 1'b0;
                                n_state = S_READ;
                            end
                        end
                        REQ_ENQUEUE: begin
                            ld = 1'b1;
                            if (!r_ne) begin
                                q_we    = 1'b1;
                                q_waddr = '0;
                                n_head  = '0;
                                n_tail  = '0;
                                n_ne    = 1'b1;
                            end else if (queue_can_take) begin
                                q_we   = 1'b1;
                                n_tail = tail_p1;
                            end else begin
                                ld_status = ST_FULL;
                            end
                        end
                        REQ_DEQUEUE: begin
                            if (!r_ne) begin
                                ld        = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                q_re    = 1'b1;
                                n_rd_q  = 1'b1;
                                n_state = S_READ;
                                if (r_head == r_tail) begin
                                    n_head = '0;
                                    n_tail = '0;
                                    n_ne   = 1'b0;
                                end else begin
                                    n_head = head_p1;
                                end
                            end
                        end
                        REQ_SWITCH: begin
                            n_mode  = !r_mode;
                            n_pend  = 1'b0;
                            n_state = S_XFER;
                        end
                        default: begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                ld      = 1'b1;
                ld_data = r_rd_q ? q_rdata : s_rdata;
                n_state = S_IDLE;
            end

            S_XFER: begin
                // Finish the entry read in the previous cycle.
                n_pend = 1'b0;
                if (r_pend) begin
                    if (r_mode) begin
                        q_we    = 1'b1;
                        q_waddr = r_wr_addr;
                        q_wdata = s_rdata;
                    end else begin
                        s_we    = 1'b1;
                        s_waddr = r_wr_addr;
                        s_wdata = q_rdata;
                    end
                end

                if (r_mode) begin
                    // Stack to queue: pop the top, append it at the tail.
                    if (r_fill == '0) begin
                        ld      = 1'b1;
                        n_state = S_IDLE;
                    end else if (!queue_can_take) begin
                        ld        = 1'b1;
                        ld_status = ST_FULL;
                        n_state   = S_IDLE;
                    end else begin
                        s_re   = 1'b1;
                        n_fill = fill_m1;
                        n_pend = 1'b1;
                        if (!r_ne) begin
                            n_head    = '0;
                            n_tail    = '0;
                            n_ne      = 1'b1;
                            n_wr_addr = '0;
                        end else begin
                            n_tail    = tail_p1;
                            n_wr_addr = tail_p1;
                        end
                    end
                end else begin
                    // Queue to stack: take the front, push it on the stack.
                    if (!r_ne) begin
                        ld      = 1'b1;
                        n_state = S_IDLE;
                    end else if (stack_full) begin
                        ld        = 1'b1;
                        ld_status = ST_FULL;
                        n_state   = S_IDLE;
                    end else begin
                        q_re      = 1'b1;
                        n_pend    = 1'b1;
                        n_wr_addr = r_fill[ADDR_W-1:0];
                        n_fill    = r_fill + CNT_W'(1);
                        if (r_head == r_tail) begin
                            n_head = '0;
                            n_tail = '0;
                            n_ne   = 1'b0;
                        end else begin
                            n_head = head_p1;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Counts in a result beat describe the store after the request.
    assign ld_qcnt = n_ne ? (CNT_W'(n_tail) - CNT_W'(n_head) + CNT_W'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_ne        <= 1'b0;
            r_mode      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_ne    <= n_ne;
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_rd_q    <= n_rd_q;
        if (ld) begin
            r_out_data   <= ld_data;
            r_out_status <= ld_status;
            r_out_mode   <= n_mode;
            r_out_scnt   <= OUT_CNT_W'(n_fill);
            r_out_qcnt   <= OUT_CNT_W'(ld_qcnt);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data        = r_out_data;
    assign o_status      = r_out_status;
    assign o_mode_now    = r_out_mode;
    assign o_stack_count = r_out_scnt;
    assign o_queue_count = r_out_qcnt;

    // The stack never holds more than its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("stack fill beyond depth");

    // A write still owed from a transfer exists only inside the transfer.
    a_pend_in_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_XFER))
        else $error("pending transfer write outside transfer");

    // An empty queue has its indices back at slot zero.
    a_queue_reset_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ne |-> (r_head == '0 && r_tail == '0))
        else $error("empty queue with nonzero indices");

    // A result is never loaded over a beat that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && r_out_valid) |-> !i_out_stall)
        else $error("result register overwritten");

    // The read state always follows an accepted request.
    a_read_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> $past(accept))
        else $error("read state without a request");

endmodule
